### rtl/core/compass_sobel_convolution_top_macros.svh
// assertion macros used by the compass sobel filter rtl
`ifndef COMPASS_SOBEL_CONVOLUTION_TOP_MACROS_SVH
`define COMPASS_SOBEL_CONVOLUTION_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define CSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/cssc_pkg.sv
// shared constants, types and kernel table for the compass sobel filter
`default_nettype none

package cssc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int CH_W       = 8;
  localparam int CHANS      = 3;
  localparam int PIX_W      = CH_W * CHANS;
  localparam int KROWS      = 3;
  localparam int SUM_W      = 11;
  localparam int ACC_W      = 12;
  localparam int KSEL_W     = 3;
  localparam int NKERN      = 8;
  localparam int WCFG_W     = COL_W + 1;
  localparam int HCFG_W     = 13;
  localparam int CFG_DATA_W = (WCFG_W > HCFG_W) ? WCFG_W : HCFG_W;
  localparam int CFG_IDX_W  = 2;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // result slots an input pixel may open, emitted lowest first
  localparam int RES_MAX    = 3;
  localparam int SLOT_MAIN  = 0;
  localparam int SLOT_EOR   = 1;
  localparam int SLOT_LAST  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cssc_cfg_idx_t;

  typedef logic [PIX_W-1:0] cssc_pix_t;

  // compass kernels E, NE, N, NW, W, SW, S, SE
  localparam logic signed [2:0] KERNEL_TAB [NKERN][KROWS][KROWS] = '{
    '{'{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2,  3'sd0,  3'sd2}, '{-3'sd1,  3'sd0,  3'sd1}},
    '{'{ 3'sd0,  3'sd1,  3'sd2}, '{-3'sd1,  3'sd0,  3'sd1}, '{-3'sd2, -3'sd1,  3'sd0}},
    '{'{ 3'sd1,  3'sd2,  3'sd1}, '{ 3'sd0,  3'sd0,  3'sd0}, '{-3'sd1, -3'sd2, -3'sd1}},
    '{'{ 3'sd2,  3'sd1,  3'sd0}, '{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd0, -3'sd1, -3'sd2}},
    '{'{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd2,  3'sd0, -3'sd2}, '{ 3'sd1,  3'sd0, -3'sd1}},
    '{'{ 3'sd0, -3'sd1, -3'sd2}, '{ 3'sd1,  3'sd0, -3'sd1}, '{ 3'sd2,  3'sd1,  3'sd0}},
    '{'{-3'sd1, -3'sd2, -3'sd1}, '{ 3'sd0,  3'sd0,  3'sd0}, '{ 3'sd1,  3'sd2,  3'sd1}},
    '{'{-3'sd2, -3'sd1,  3'sd0}, '{-3'sd1,  3'sd0,  3'sd1}, '{ 3'sd0,  3'sd1,  3'sd2}}
  };

  // pixel held between the accept stage and the kernel stage
  typedef struct packed {
    logic [RES_MAX-1:0] mask;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   last_col;
    logic [ROW_W-1:0]   main_row;
    logic [COL_W-1:0]   main_col;
    logic               calc;
    cssc_pix_t          pix;
  } cssc_stage_t;

  // everything the result sequencer needs for one pixel
  typedef struct packed {
    logic [RES_MAX-1:0]     mask;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [COL_W-1:0]       last_col;
    logic [ROW_W-1:0]       main_row;
    logic [COL_W-1:0]       main_col;
    logic signed [SUM_W-1:0] sum_zero;
    logic signed [SUM_W-1:0] sum_one;
    logic signed [SUM_W-1:0] sum_two;
  } cssc_emit_t;

endpackage

`default_nettype wire

### rtl/core/cssc_ifs.sv
// valid/ready stream interfaces for pixels in and edge results out
`default_nettype none

interface cssc_pix_if;
  import cssc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] chan_zero;
  logic [CH_W-1:0] chan_one;
  logic [CH_W-1:0] chan_two;
  modport source (output valid, output chan_zero, output chan_one, output chan_two,
                  input ready);
  modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                  output ready);
endinterface

interface cssc_res_if;
  import cssc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_column;
  logic signed [SUM_W-1:0] edge_zero;
  logic signed [SUM_W-1:0] edge_one;
  logic signed [SUM_W-1:0] edge_two;
  logic                    run_last;
  modport source (output valid, output out_row, output out_column, output edge_zero,
                  output edge_one, output edge_two, output run_last, input ready);
  modport sink   (input valid, input out_row, input out_column, input edge_zero,
                  input edge_one, input edge_two, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/core/cssc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module cssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/cssc_conv.sv
// 3x3 window columns and per-channel compass kernel sums
`default_nettype none

module cssc_conv (
  input  logic                                         clk,
  input  logic                                         shift_en,
  input  logic                                         calc,
  input  logic [cssc_pkg::KSEL_W-1:0]                  kernel_sel,
  input  logic [cssc_pkg::KROWS-1:0][cssc_pkg::PIX_W-1:0] col,
  output logic signed [cssc_pkg::SUM_W-1:0]            sum_zero,
  output logic signed [cssc_pkg::SUM_W-1:0]            sum_one,
  output logic signed [cssc_pkg::SUM_W-1:0]            sum_two
);
  import cssc_pkg::*;

  // signed coefficient times unsigned channel byte
  function automatic logic signed [ACC_W-1:0] tap_prod(input logic signed [2:0] coef,
                                                       input logic [CH_W-1:0] px);
    logic signed [ACC_W-1:0] c_ext;
    logic signed [ACC_W-1:0] p_ext;
    c_ext = ACC_W'(coef);
    p_ext = $signed({{(ACC_W - CH_W){1'b0}}, px});
    return c_ext * p_ext;
  endfunction

  // two older columns per window row
  logic [PIX_W-1:0] win_r [KROWS][2];

  logic [PIX_W-1:0]        tap     [KROWS][KROWS];
  logic signed [ACC_W-1:0] prod    [CHANS][KROWS][KROWS];
  logic signed [ACC_W-1:0] row_sum [CHANS][KROWS];
  logic signed [ACC_W-1:0] total   [CHANS];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < KROWS; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= col[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < KROWS; r++) begin
      tap[r][0] = win_r[r][0];
      tap[r][1] = win_r[r][1];
      tap[r][2] = col[r];
    end
  end

  // products, then row sums, then the three-row total
  always_comb begin
    for (int z = 0; z < CHANS; z++) begin
      for (int r = 0; r < KROWS; r++) begin
        for (int c = 0; c < KROWS; c++) begin
          prod[z][r][c] = tap_prod(KERNEL_TAB[kernel_sel][r][c], tap[r][c][CH_W*z +: CH_W]);
        end
        row_sum[z][r] = prod[z][r][0] + prod[z][r][1] + prod[z][r][2];
      end
      total[z] = row_sum[z][0] + row_sum[z][1] + row_sum[z][2];
    end
  end

  assign sum_zero = calc ? SUM_W'(total[0]) : '0;
  assign sum_one  = calc ? SUM_W'(total[1]) : '0;
  assign sum_two  = calc ? SUM_W'(total[2]) : '0;

endmodule

`default_nettype wire

### rtl/core/cssc_emit.sv
// result register that plays out up to three results per pixel
`default_nettype none
`include "compass_sobel_convolution_top_macros.svh"

module cssc_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  cssc_pkg::cssc_emit_t item,
  output logic                 item_ready,
  cssc_res_if.source           res
);
  import cssc_pkg::*;

  logic [RES_MAX-1:0] mask_r;
  logic [RES_MAX-1:0] mask_nxt;
  cssc_emit_t         item_r;
  logic               single;
  logic               fire;
  logic               load;

  assign single     = (mask_r & (mask_r - RES_MAX'(1))) == '0;
  assign fire       = res.valid && res.ready;
  assign item_ready = !res.valid || (res.ready && single);
  assign load       = item_valid && item_ready;

  always_comb begin
    mask_nxt = mask_r;
    if (fire) begin
      mask_nxt = mask_r & (mask_r - RES_MAX'(1));
    end
    if (load) begin
      mask_nxt = item.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign res.valid    = |mask_r;
  assign res.run_last = single;

  // main result first, then end-of-row zero, then last-row zero
  always_comb begin
    res.out_row    = item_r.main_row;
    res.out_column = item_r.main_col;
    res.edge_zero  = item_r.sum_zero;
    res.edge_one   = item_r.sum_one;
    res.edge_two   = item_r.sum_two;
    if (!mask_r[SLOT_MAIN]) begin
      res.edge_zero = '0;
      res.edge_one  = '0;
      res.edge_two  = '0;
      if (mask_r[SLOT_EOR]) begin
        res.out_row    = item_r.row - ROW_W'(1);
        res.out_column = item_r.last_col;
      end else begin
        res.out_row    = item_r.row;
        res.out_column = item_r.col;
      end
    end
  end

  `CSSC_ASSERT_IMP(a_border_zero, clk, rst_n, res.valid && (res.out_row == '0 || res.out_column == '0), res.edge_zero == '0 && res.edge_one == '0 && res.edge_two == '0, "border result carries a nonzero sum")
  `CSSC_ASSERT_NXT(a_run_continues, clk, rst_n, res.valid && res.ready && !res.run_last, res.valid, "result run ended before its last transaction")
  `CSSC_ASSERT_NXT(a_row_order, clk, rst_n, res.valid && res.ready && !res.run_last, res.out_row >= $past(res.out_row), "results of one pixel went back a row")

endmodule

`default_nettype wire

### rtl/core/compass_sobel_convolution_top.sv
// top level of the streaming 3x3 compass sobel edge filter
//
// Pixels of three 8-bit channels enter in raster order on in_pix, one transaction
// per pixel; out_res gives signed 11-bit kernel sums per channel, each tagged with
// its row and column, and run_last marks the final result of one pixel. A pixel
// on row 0 gives its own zero result; a later pixel at (i,j) gives the result for
// (i-1,j-1) when j is not 0, adds the zero result for (i-1,W-1) at the row end,
// and on the last row adds its own zero result. The pipeline is two registers
// deep: a pixel is accepted and its line-store column read in the same cycle,
// the kernel sums are formed in the next cycle, and the result register drives
// out_res. A pixel with one result (or none) frees the result register, so pixels
// stream at one per clock while out_res is ready; one with two or three results
// holds it until its last result is taken, since the single result port moves
// one transaction per clock. Both line stores share one 1024 x 48 memory with one
// write and one read port; no clearing pass is needed after reset. The user must
// write configuration (kernel, width, height) through cfg_we/cfg_index/cfg_data
// only while no pixel is in flight; the block does not enforce it.
`default_nettype none

module compass_sobel_convolution_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cssc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cssc_pkg::CFG_DATA_W-1:0]   cfg_data,
  cssc_pix_if.sink                          in_pix,
  cssc_res_if.source                        out_res
);
  import cssc_pkg::*;

  // configuration registers
  logic [KSEL_W-1:0] ksel_r,   ksel_nxt;
  logic [WCFG_W-1:0] width_r,  width_nxt;
  logic [HCFG_W-1:0] height_r, height_nxt;

  // frame position of the next pixel
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  // kernel stage
  logic        s1_valid_r, s1_valid_nxt;
  cssc_stage_t s1_r, s1_nxt;

  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             in_fire;
  logic             s1_go;
  logic             emit_ready;
  cssc_emit_t       emit_item;

  logic [2*PIX_W-1:0]               line_rd;
  logic [KROWS-1:0][PIX_W-1:0]      win_col;
  logic signed [SUM_W-1:0]          sum_zero, sum_one, sum_two;

  // register writes
  always_comb begin
    ksel_nxt   = ksel_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL: ksel_nxt   = cfg_data[KSEL_W-1:0];
        CFG_WIDTH:  width_nxt  = cfg_data[WCFG_W-1:0];
        CFG_HEIGHT: height_nxt = cfg_data[HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksel_r   <= '0;
      width_r  <= WCFG_W'(WIDTH_RST);
      height_r <= HCFG_W'(HEIGHT_RST);
    end else begin
      ksel_r   <= ksel_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // sizes out of range act as the nearest legal size
  always_comb begin
    if (width_r < WCFG_W'(MIN_SIZE)) begin
      last_col = COL_W'(MIN_SIZE - 1);
    end else if (width_r > WCFG_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(width_r - WCFG_W'(1));
    end
    if (height_r < HCFG_W'(MIN_SIZE)) begin
      last_row = ROW_W'(MIN_SIZE - 1);
    end else if (height_r > HCFG_W'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(height_r - HCFG_W'(1));
    end
  end

  // counters past a smaller frame clamp to its last row or column
  assign cur_col = (col_cnt_r > last_col) ? last_col : col_cnt_r;
  assign cur_row = (row_cnt_r > last_row) ? last_row : row_cnt_r;

  // handshakes: the kernel stage moves whenever the result register can take it
  assign s1_go         = s1_valid_r && emit_ready;
  assign in_pix.ready  = !s1_valid_r || emit_ready;
  assign in_fire       = in_pix.valid && in_pix.ready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (cur_col == last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (cur_row == last_row) ? '0 : cur_row + ROW_W'(1);
      end else begin
        col_cnt_nxt = cur_col + COL_W'(1);
        row_cnt_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // decide which results this pixel opens
  always_comb begin
    s1_nxt.row      = cur_row;
    s1_nxt.col      = cur_col;
    s1_nxt.last_col = last_col;
    s1_nxt.pix      = {in_pix.chan_two, in_pix.chan_one, in_pix.chan_zero};
    s1_nxt.mask     = '0;
    s1_nxt.calc     = 1'b0;
    if (cur_row == '0) begin
      // first row: zero result for the pixel itself
      s1_nxt.mask[SLOT_MAIN] = 1'b1;
      s1_nxt.main_row        = cur_row;
      s1_nxt.main_col        = cur_col;
    end else begin
      s1_nxt.mask[SLOT_MAIN] = cur_col != '0;
      s1_nxt.mask[SLOT_EOR]  = cur_col == last_col;
      s1_nxt.mask[SLOT_LAST] = cur_row == last_row;
      s1_nxt.main_row        = cur_row - ROW_W'(1);
      s1_nxt.main_col        = cur_col - COL_W'(1);
      // full window only away from the top and left border
      s1_nxt.calc            = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // line stores: upper half older row, lower half newer row; read on accept,
  // written back (newer moves to older, pixel becomes newer) as the stage leaves
  cssc_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_r.col),
    .wr_data ({line_rd[PIX_W-1:0], s1_r.pix}),
    .rd_en   (in_fire),
    .rd_addr (cur_col),
    .rd_data (line_rd)
  );

  // newest column of the window, top row first
  assign win_col[0] = line_rd[2*PIX_W-1:PIX_W];
  assign win_col[1] = line_rd[PIX_W-1:0];
  assign win_col[2] = s1_r.pix;

  cssc_conv u_conv (
    .clk        (clk),
    .shift_en   (s1_go),
    .calc       (s1_r.calc),
    .kernel_sel (ksel_r),
    .col        (win_col),
    .sum_zero   (sum_zero),
    .sum_one    (sum_one),
    .sum_two    (sum_two)
  );

  always_comb begin
    emit_item.mask     = s1_r.mask;
    emit_item.row      = s1_r.row;
    emit_item.col      = s1_r.col;
    emit_item.last_col = s1_r.last_col;
    emit_item.main_row = s1_r.main_row;
    emit_item.main_col = s1_r.main_col;
    emit_item.sum_zero = sum_zero;
    emit_item.sum_one  = sum_one;
    emit_item.sum_two  = sum_two;
  end

  // result register and sequencing of the results of one pixel
  cssc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (emit_item),
    .item_ready (emit_ready),
    .res        (out_res)
  );

endmodule

`default_nettype wire
